// File: sv/pat_pkg.sv
package pat_pkg;

    localparam int unsigned DEPTH_DEF       = 16;
    localparam int unsigned MAX_PER_SRC_DEF = 8;
    localparam int unsigned LOOKUP_CAP      = 8;

    localparam logic [7:0]  EMPTY_BYTE     = 8'hB4;
    localparam logic [7:0]  EMPTY_UNIT_RST = 8'd15;
    localparam logic [15:0] EMPTY_DID_RST  = {EMPTY_BYTE, EMPTY_BYTE};

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_EMPTY_UNIT = 1'b0;
    localparam logic REG_EMPTY_DID  = 1'b1;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  src_node;
        logic [15:0] peer_dev;
        logic [7:0]  peer_node;
    } t_in;

    typedef struct packed {
        logic        status;
        logic        match_valid;
        logic [15:0] match_did;
        logic [7:0]  match_unit;
        logic [4:0]  entry_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0]  src;
        logic [15:0] did;
        logic [7:0]  unit;
    } t_entry;

    typedef struct packed {
        logic ent_vac;
        logic key_vac;
        logic src_eq;
        logic exact;
        logic wild_hit;
    } t_cmp;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REM,
        S_FILL,
        S_CNT,
        S_LOOK,
        S_DONE
    } t_state;

endpackage

// File: sv/pat_cfg.sv
module pat_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pat_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pat_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pat_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [7:0]                          o_empty_unit,
    output logic [15:0]                         o_empty_did
);

    logic [7:0]  r_empty_unit;
    logic [15:0] r_empty_did;
    logic        reg_sel;

    assign reg_sel = paddr[pat_pkg::APB_ADDR_W-1];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_unit <= pat_pkg::EMPTY_UNIT_RST;
            r_empty_did  <= pat_pkg::EMPTY_DID_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                pat_pkg::REG_EMPTY_UNIT: r_empty_unit <= pwdata[7:0];
                pat_pkg::REG_EMPTY_DID:  r_empty_did  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            pat_pkg::REG_EMPTY_UNIT: prdata = {24'd0, r_empty_unit};
            pat_pkg::REG_EMPTY_DID:  prdata = {16'd0, r_empty_did};
            default:                 prdata = '0;
        endcase
    end

    assign o_empty_unit = r_empty_unit;
    assign o_empty_did  = r_empty_did;

endmodule

// File: sv/pat_mem.sv
module pat_mem #(
    parameter  int unsigned DEPTH = pat_pkg::DEPTH_DEF,
    localparam int unsigned IW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pat_pkg::t_mem_ctl   i_ctl,
    input  logic [IW-1:0]       i_rd_addr,
    input  logic [IW-1:0]       i_wr_addr,
    input  pat_pkg::t_entry     i_wr_data,
    input  logic [7:0]          i_fill_unit,
    input  logic [15:0]         i_fill_did,
    output pat_pkg::t_entry     o_rd_data
);

    pat_pkg::t_entry r_mem [DEPTH];
    pat_pkg::t_entry r_rd_raw;
    logic            r_rd_vld;
    logic [DEPTH-1:0] r_valid;
    logic [7:0]      r_fill_unit;
    logic [15:0]     r_fill_did;

    // Entries not written since the last clear read as the codes latched at that clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fill_unit <= pat_pkg::EMPTY_UNIT_RST;
            r_fill_did  <= pat_pkg::EMPTY_DID_RST;
        end else if (i_ctl.clear) begin
            r_valid     <= '0;
            r_fill_unit <= i_fill_unit;
            r_fill_did  <= i_fill_did;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_raw <= r_mem[i_rd_addr];
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw :
                       pat_pkg::t_entry'{src: r_fill_unit, did: r_fill_did,
                                         unit: r_fill_unit};

endmodule

// File: sv/pat_cmp.sv
module pat_cmp (
    input  pat_pkg::t_entry i_entry,
    input  pat_pkg::t_in    i_key,
    input  logic [7:0]      i_empty_unit,
    input  logic [15:0]     i_empty_did,
    output pat_pkg::t_cmp   o_cmp
);

    logic src_eq;
    logic did_eq;
    logic unit_eq;

    assign src_eq  = (i_entry.src  == i_key.src_node);
    assign did_eq  = (i_entry.did  == i_key.peer_dev);
    assign unit_eq = (i_entry.unit == i_key.peer_node);

    assign o_cmp.ent_vac  = (i_entry.unit == i_empty_unit);
    assign o_cmp.key_vac  = (i_key.peer_node == i_empty_unit);
    assign o_cmp.src_eq   = src_eq;
    assign o_cmp.exact    = src_eq && did_eq && unit_eq;
    assign o_cmp.wild_hit = (did_eq || (i_key.peer_dev == i_empty_did)) &&
                            (src_eq || (i_key.src_node == i_empty_unit)) &&
                            (unit_eq || (i_key.peer_node == i_empty_unit));

endmodule

// File: sv/pat_ctrl.sv
module pat_ctrl #(
    parameter  int unsigned DEPTH       = pat_pkg::DEPTH_DEF,
    parameter  int unsigned MAX_PER_SRC = pat_pkg::MAX_PER_SRC_DEF,
    localparam int unsigned IW          = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pat_pkg::t_in        i_cmd,
    output logic                o_strobe,
    output pat_pkg::t_out       o_result,
    input  logic [7:0]          i_empty_unit,
    output pat_pkg::t_in        o_key,
    input  pat_pkg::t_cmp       i_cmp,
    output pat_pkg::t_mem_ctl   o_mem_ctl,
    output logic [IW-1:0]       o_rd_addr,
    output logic [IW-1:0]       o_wr_addr,
    output pat_pkg::t_entry     o_wr_data,
    input  pat_pkg::t_entry     i_rd_data
);

    localparam int unsigned CW       = $clog2(DEPTH + 1);
    localparam int unsigned NW       = $clog2(MAX_PER_SRC + 1);
    localparam int unsigned LOOK_LIM = (MAX_PER_SRC < pat_pkg::LOOKUP_CAP) ?
                                       MAX_PER_SRC : pat_pkg::LOOKUP_CAP;
    localparam int unsigned LW       = $clog2(LOOK_LIM + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [NW-1:0] MAX_C   = NW'(MAX_PER_SRC);
    localparam logic [LW-1:0] LOOK_C  = LW'(LOOK_LIM);

    pat_pkg::t_state r_state, n_state;
    pat_pkg::t_in    r_cmd, n_cmd;
    pat_pkg::t_out   r_out, n_out;
    logic            r_strobe, n_strobe;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_pv, n_pv;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic [CW-1:0]   r_w, n_w;
    logic [NW-1:0]   r_n, n_n;
    logic [LW-1:0]   r_emit, n_emit;
    logic            r_decided, n_decided;
    logic            r_status, n_status;
    logic            r_found, n_found;
    logic [CW-1:0]   r_count, n_count;
    logic [7:0]      r_last_src, n_last_src;
    logic [15:0]     r_last_did, n_last_did;

    logic            scan;
    logic            rd_en;
    logic [CW-1:0]   lim;
    logic            last_one;
    logic [CW-1:0]   idx_c;
    logic [NW-1:0]   n_inc;
    logic [LW-1:0]   emit_inc;
    logic            eff_vac;
    logic            wr_here;
    logic            hit;
    logic [CW+4:0]   cnt_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pat_pkg::S_IDLE;
            r_strobe  <= 1'b0;
            r_ptr     <= '0;
            r_pv      <= 1'b0;
            r_pidx    <= '0;
            r_w       <= '0;
            r_n       <= '0;
            r_emit    <= '0;
            r_decided <= 1'b0;
            r_status  <= 1'b0;
            r_found   <= 1'b0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_ptr     <= n_ptr;
            r_pv      <= n_pv;
            r_pidx    <= n_pidx;
            r_w       <= n_w;
            r_n       <= n_n;
            r_emit    <= n_emit;
            r_decided <= n_decided;
            r_status  <= n_status;
            r_found   <= n_found;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out      <= n_out;
        r_last_src <= n_last_src;
        r_last_did <= n_last_did;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_out      = r_out;
        n_strobe   = 1'b0;
        n_w        = r_w;
        n_n        = r_n;
        n_emit     = r_emit;
        n_decided  = r_decided;
        n_status   = r_status;
        n_found    = r_found;
        n_count    = r_count;
        n_last_src = r_last_src;
        n_last_did = r_last_did;
        o_mem_ctl  = '0;
        o_wr_addr  = r_w[IW-1:0];
        o_wr_data  = i_rd_data;
        eff_vac    = 1'b0;
        wr_here    = 1'b0;
        hit        = 1'b0;
        cnt_ext    = {5'd0, r_count};

        scan = (r_state == pat_pkg::S_ADD) || (r_state == pat_pkg::S_REM) ||
               (r_state == pat_pkg::S_CNT) || (r_state == pat_pkg::S_LOOK);
        lim      = (r_state == pat_pkg::S_LOOK) ? r_count : DEPTH_C;
        rd_en    = scan && (r_ptr < lim);
        idx_c    = CW'(r_pidx);
        last_one = (idx_c == (lim - CW'(1)));
        n_inc    = r_n + NW'(1);
        emit_inc = r_emit + LW'(1);
        o_mem_ctl.rd_en = rd_en;
        n_ptr    = rd_en ? (r_ptr + CW'(1)) : r_ptr;

        case (r_state)
            pat_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_w       = '0;
                    n_n       = '0;
                    n_emit    = '0;
                    n_decided = 1'b0;
                    n_found   = 1'b0;
                    n_status  = 1'b0;
                    case (i_cmd.func)
                        pat_pkg::FUNC_ADD:    n_state = pat_pkg::S_ADD;
                        pat_pkg::FUNC_REMOVE: n_state = pat_pkg::S_REM;
                        pat_pkg::FUNC_LOOKUP: n_state = pat_pkg::S_CNT;
                        default: begin
                            o_mem_ctl.clear = 1'b1;
                            n_count         = '0;
                            n_state         = pat_pkg::S_DONE;
                        end
                    endcase
                end
            end
            pat_pkg::S_ADD: begin
                if (r_pv) begin
                    wr_here = !r_decided && i_cmp.ent_vac;
                    if (!r_decided) begin
                        if (i_cmp.ent_vac) begin
                            o_mem_ctl.wr_en = 1'b1;
                            o_wr_addr       = r_pidx;
                            o_wr_data       = '{src: r_cmd.src_node, did: r_cmd.peer_dev,
                                                unit: r_cmd.peer_node};
                            n_decided       = 1'b1;
                            n_status        = 1'b0;
                        end else if (i_cmp.src_eq) begin
                            if (i_cmp.exact) begin
                                n_decided = 1'b1;
                                n_status  = 1'b0;
                            end else begin
                                n_n = n_inc;
                                if (n_inc >= MAX_C) begin
                                    n_decided = 1'b1;
                                    n_status  = 1'b1;
                                end
                            end
                        end
                    end
                    eff_vac = wr_here ? i_cmp.key_vac : i_cmp.ent_vac;
                    if (!r_found && eff_vac) begin
                        n_found = 1'b1;
                        n_count = idx_c;
                    end
                    if (last_one) begin
                        if (!n_found) begin
                            n_count = DEPTH_C;
                        end
                        if (!n_decided) begin
                            n_status = 1'b1;
                        end
                        n_state = pat_pkg::S_DONE;
                    end
                end
            end
            pat_pkg::S_REM: begin
                if (r_pv) begin
                    if (!r_found && i_cmp.ent_vac) begin
                        n_found = 1'b1;
                        n_count = r_w;
                    end
                    hit = !r_found && !i_cmp.ent_vac && i_cmp.wild_hit;
                    if (!hit) begin
                        o_mem_ctl.wr_en = 1'b1;
                        n_w             = r_w + CW'(1);
                    end
                    if (idx_c == (DEPTH_C - CW'(1))) begin
                        n_last_src = i_rd_data.src;
                        n_last_did = i_rd_data.did;
                    end
                    if (last_one) begin
                        if (!n_found) begin
                            n_count = n_w;
                        end
                        n_state = pat_pkg::S_FILL;
                    end
                end
            end
            pat_pkg::S_FILL: begin
                if (r_w == DEPTH_C) begin
                    n_state = pat_pkg::S_DONE;
                end else begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_wr_data       = '{src: r_last_src, did: r_last_did, unit: i_empty_unit};
                    n_w             = r_w + CW'(1);
                end
            end
            pat_pkg::S_CNT: begin
                if (r_pv) begin
                    if (i_cmp.ent_vac || last_one) begin
                        n_count = i_cmp.ent_vac ? idx_c : DEPTH_C;
                        if (n_count == '0) begin
                            n_state = pat_pkg::S_DONE;
                        end else begin
                            n_state = pat_pkg::S_LOOK;
                        end
                    end
                end
            end
            pat_pkg::S_LOOK: begin
                if (r_pv) begin
                    if (i_cmp.src_eq) begin
                        n_strobe = 1'b1;
                        n_out    = '{status: 1'b0, match_valid: 1'b1,
                                     match_did: i_rd_data.did, match_unit: i_rd_data.unit,
                                     entry_count: cnt_ext[4:0], last: 1'b0};
                        n_emit   = emit_inc;
                        if (emit_inc == LOOK_C) begin
                            n_state = pat_pkg::S_DONE;
                        end
                    end
                    if (last_one) begin
                        n_state = pat_pkg::S_DONE;
                    end
                end
            end
            pat_pkg::S_DONE: begin
                n_strobe = 1'b1;
                n_out    = '{status: r_status, match_valid: 1'b0, match_did: 16'd0,
                             match_unit: 8'd0, entry_count: cnt_ext[4:0], last: 1'b1};
                n_state  = pat_pkg::S_IDLE;
            end
            default: begin
                n_state = pat_pkg::S_IDLE;
            end
        endcase

        n_pv   = rd_en && (n_state == r_state);
        n_pidx = r_ptr[IW-1:0];
        if (n_state != r_state) begin
            n_ptr = '0;
        end
    end

    assign busy      = (r_state != pat_pkg::S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_result  = r_out;
    assign o_key     = r_cmd;
    assign o_rd_addr = r_ptr[IW-1:0];

endmodule

// File: sv/peer_assignment_table.sv
// Channel   Direction  Handshake                        Payload
// command   in         start high while busy low        i_cmd  (pat_pkg::t_in)
// result    out        o_strobe, one cycle per result   o_result (pat_pkg::t_out)
// config    in/out     APB write when psel,penable,pwrite,pready
//                                                       pwdata / prdata
//
// One command is worked at a time by a sequencer that walks the table one entry per
// cycle through a single read port and a single compare unit.
// Add walks the whole table; remove walks it and refills the freed tail; lookup
// counts and walks the used entries; busy stays high until the final result shows.
// After reset the table reads as empty at once; no clearing pass is needed.
// Results cannot be stalled: each one is on the ports for exactly one cycle.
module peer_assignment_table #(
    parameter int unsigned TABLE_DEPTH    = pat_pkg::DEPTH_DEF,
    parameter int unsigned MAX_PER_SOURCE = pat_pkg::MAX_PER_SRC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pat_pkg::t_in                    i_cmd,
    output logic                            o_strobe,
    output pat_pkg::t_out                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pat_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pat_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pat_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int unsigned IW = $clog2(TABLE_DEPTH);

    logic [7:0]        empty_unit;
    logic [15:0]       empty_did;
    pat_pkg::t_in      key;
    pat_pkg::t_cmp     cmp;
    pat_pkg::t_mem_ctl mem_ctl;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    pat_pkg::t_entry   wr_data;
    pat_pkg::t_entry   rd_data;

    pat_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_empty_unit (empty_unit),
        .o_empty_did  (empty_did)
    );

    pat_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mem_ctl),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_fill_unit (empty_unit),
        .i_fill_did  (empty_did),
        .o_rd_data   (rd_data)
    );

    pat_cmp u_cmp (
        .i_entry      (rd_data),
        .i_key        (key),
        .i_empty_unit (empty_unit),
        .i_empty_did  (empty_did),
        .o_cmp        (cmp)
    );

    pat_ctrl #(
        .DEPTH       (TABLE_DEPTH),
        .MAX_PER_SRC (MAX_PER_SOURCE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_strobe     (o_strobe),
        .o_result     (o_result),
        .i_empty_unit (empty_unit),
        .o_key        (key),
        .i_cmp        (cmp),
        .o_mem_ctl    (mem_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_rd_data    (rd_data)
    );

endmodule

// File: sv/pat_chk.sv
module pat_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input pat_pkg::t_out o_result
);

    // A result only ever comes out of a transaction that was in progress.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> (!busy && !o_result.match_valid))
        else $error("final result shown while still busy or carrying a match");

    a_match_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.match_valid) |-> (busy && !o_result.last &&
                                                !o_result.status))
        else $error("matched entry result not followed by a closing result");

endmodule

bind peer_assignment_table pat_chk u_pat_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: sim/peer_table_monitor.sv
module peer_table_monitor
    import pat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in                   i_cmd,
    input  logic                  i_strobe,
    input  t_out                  i_result,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int DEPTH = DEPTH_DEF;

    t_entry      shadow_table [DEPTH];
    logic [7:0]  vacant_unit;
    logic [15:0] vacant_did;
    t_out        awaited_results [$];
    int          error_count = 0;

    function automatic int unsigned used_entries();
        for (int i = 0; i < DEPTH; i++) begin
            if (shadow_table[i].unit == vacant_unit) begin
                return i;
            end
        end
        return DEPTH;
    endfunction

    function automatic void push_result(logic status, logic valid, logic [15:0] did,
                                        logic [7:0] unit, logic last);
        t_out r;
        r.status      = status;
        r.match_valid = valid;
        r.match_did   = did;
        r.match_unit  = unit;
        r.entry_count = 5'(used_entries());
        r.last        = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < DEPTH; i++) begin
            shadow_table[i].src  = vacant_unit;
            shadow_table[i].did  = vacant_did;
            shadow_table[i].unit = vacant_unit;
        end
    endfunction

    function automatic logic add_assignment(t_in c);
        int unsigned same_src;
        same_src = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (shadow_table[i].unit == vacant_unit) begin
                shadow_table[i].src  = c.src_node;
                shadow_table[i].did  = c.peer_dev;
                shadow_table[i].unit = c.peer_node;
                return 1'b0;
            end
            if (shadow_table[i].src == c.src_node) begin
                if (shadow_table[i].unit == c.peer_node &&
                    shadow_table[i].did == c.peer_dev) begin
                    return 1'b0;
                end
                same_src++;
                if (same_src >= MAX_PER_SRC_DEF) begin
                    return 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void remove_matches(t_in c);
        int   i;
        logic hit;
        i = 0;
        while (i < DEPTH) begin
            if (shadow_table[i].unit == vacant_unit) begin
                break;
            end
            hit = (c.peer_dev == vacant_did || c.peer_dev == shadow_table[i].did) &&
                  (c.src_node == vacant_unit || c.src_node == shadow_table[i].src) &&
                  (c.peer_node == vacant_unit || c.peer_node == shadow_table[i].unit);
            if (hit) begin
                for (int j = i; j < DEPTH - 1; j++) begin
                    shadow_table[j] = shadow_table[j + 1];
                end
                shadow_table[DEPTH - 1].unit = vacant_unit;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic void list_peers(t_in c);
        int unsigned used;
        int unsigned listed;
        used   = used_entries();
        listed = 0;
        for (int i = 0; i < int'(used); i++) begin
            if (listed >= MAX_PER_SRC_DEF || listed >= LOOKUP_CAP) begin
                break;
            end
            if (shadow_table[i].src == c.src_node) begin
                push_result(1'b0, 1'b1, shadow_table[i].did, shadow_table[i].unit, 1'b0);
                listed++;
            end
        end
    endfunction

    function automatic void apply_command(t_in c);
        logic status;
        status = 1'b0;
        case (c.func)
            FUNC_ADD: begin
                status = add_assignment(c);
            end
            FUNC_REMOVE: begin
                remove_matches(c);
            end
            FUNC_LOOKUP: begin
                list_peers(c);
            end
            FUNC_CLEAR: begin
                clear_table();
            end
            default: ;
        endcase
        push_result(status, 1'b0, 16'h0000, 8'h00, 1'b1);
    endfunction

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (awaited_results.size() == 0) begin
            report($sformatf("result 0x%0h arrived with none outstanding", got));
            return;
        end
        want = awaited_results.pop_front();
        check_field("status", 16'(got.status), 16'(want.status));
        check_field("match_valid", 16'(got.match_valid), 16'(want.match_valid));
        check_field("match_did", got.match_did, want.match_did);
        check_field("match_unit", 16'(got.match_unit), 16'(want.match_unit));
        check_field("entry_count", 16'(got.entry_count), 16'(want.entry_count));
        check_field("last", 16'(got.last), 16'(want.last));
    endtask

    // Results of an earlier transaction are checked before a transaction accepted on
    // the same edge adds its own.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vacant_unit = EMPTY_UNIT_RST;
            vacant_did  = EMPTY_DID_RST;
            clear_table();
            awaited_results.delete();
        end else begin
            if (i_strobe) begin
                check_result(i_result);
            end
            if (i_start && !i_busy) begin
                apply_command(i_cmd);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_EMPTY_UNIT) begin
                    vacant_unit = i_pwdata[7:0];
                end else begin
                    vacant_did = i_pwdata[15:0];
                end
            end
        end
        o_pending = awaited_results.size();
        o_errors  = error_count;
    end

endmodule

// File: sim/tb_peer_assignment_table.sv
module tb_peer_assignment_table;
    import pat_pkg::*;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_in                   cmd     = '0;
    logic                  strobe;
    t_out                  result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    errors;

    logic [7:0]  vacant_unit = EMPTY_UNIT_RST;
    logic [15:0] vacant_did  = EMPTY_DID_RST;
    logic [7:0]  src_pool  [4];
    logic [15:0] did_pool  [4];
    logic [7:0]  unit_pool [4];
    logic        burst = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    peer_assignment_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd),
        .o_strobe (strobe),
        .o_result (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    peer_table_monitor u_table_watch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (cmd),
        .i_strobe  (strobe),
        .i_result  (result),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_pending (pending),
        .o_errors  (errors)
    );

    function automatic t_in make_cmd(logic [1:0] f, logic [7:0] s, logic [15:0] d,
                                     logic [7:0] u);
        t_in c;
        c.func      = f;
        c.src_node  = s;
        c.peer_dev  = d;
        c.peer_node = u;
        return c;
    endfunction

    function automatic logic [7:0] pick_byte(logic [7:0] pooled, int wild_pct);
        int r;
        r = $urandom_range(99);
        if (r < wild_pct) begin
            return vacant_unit;
        end else if (r < wild_pct + 12) begin
            return 8'($urandom_range(255));
        end
        return pooled;
    endfunction

    function automatic logic [15:0] pick_word(logic [15:0] pooled, int wild_pct);
        int r;
        r = $urandom_range(99);
        if (r < wild_pct) begin
            return vacant_did;
        end else if (r < wild_pct + 12) begin
            return 16'($urandom_range(65535));
        end
        return pooled;
    endfunction

    function automatic t_in random_cmd();
        int  r;
        int  wild;
        t_in c;
        r = $urandom_range(99);
        if (r < 48) begin
            c.func = FUNC_ADD;
        end else if (r < 68) begin
            c.func = FUNC_REMOVE;
        end else if (r < 94) begin
            c.func = FUNC_LOOKUP;
        end else begin
            c.func = FUNC_CLEAR;
        end
        wild        = (c.func == FUNC_REMOVE) ? 35 : 6;
        c.src_node  = pick_byte(src_pool[$urandom_range(3)], wild);
        c.peer_dev  = pick_word(did_pool[$urandom_range(3)], wild);
        c.peer_node = pick_byte(unit_pool[$urandom_range(3)], wild);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    task automatic send(t_in c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b1;
        cmd   = c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic settle(int extra);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic apb_write(logic reg_index, logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_codes(logic [7:0] unit_code, logic [15:0] did_code);
        apb_write(REG_EMPTY_UNIT, {24'h0, unit_code});
        apb_write(REG_EMPTY_DID, {16'h0, did_code});
        vacant_unit = unit_code;
        vacant_did  = did_code;
    endtask

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(make_cmd(FUNC_LOOKUP, 8'h00, 16'h0000, 8'h00));
        send(make_cmd(FUNC_ADD, 8'h00, 16'h0000, 8'h00));
        send(make_cmd(FUNC_ADD, 8'h00, 16'h0000, 8'h00));
        send(make_cmd(FUNC_ADD, 8'hFF, 16'hFFFF, 8'hFF));
        send(make_cmd(FUNC_ADD, 8'h01, 16'h0002, vacant_unit));
        for (int k = 0; k < 9; k++) begin
            send(make_cmd(FUNC_ADD, 8'h03, 16'(k), 8'(8'h20 + k)));
        end
        send(make_cmd(FUNC_LOOKUP, 8'h03, 16'h0000, 8'h00));
        send(make_cmd(FUNC_REMOVE, vacant_unit, vacant_did, 8'h21));
        for (int k = 0; k < 8; k++) begin
            send(make_cmd(FUNC_ADD, 8'(8'h40 + k), 16'(16'hA500 + k), 8'h33));
        end
        send(make_cmd(FUNC_LOOKUP, 8'hFF, 16'h0000, 8'h00));
        send(make_cmd(FUNC_REMOVE, vacant_unit, vacant_did, vacant_unit));
        send(make_cmd(FUNC_CLEAR, 8'h55, 16'h5555, 8'h55));

        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                settle(8);
                case (p)
                    1: set_codes(8'h00, 16'h0000);
                    2: set_codes(8'hFF, 16'hFFFF);
                    default: set_codes(8'($urandom_range(255)), 16'($urandom_range(65535)));
                endcase
            end
            for (int i = 0; i < 4; i++) begin
                src_pool[i]  = 8'($urandom_range(255));
                did_pool[i]  = 16'($urandom_range(65535));
                unit_pool[i] = 8'($urandom_range(255));
            end
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(24) == 0) begin
                    burst = !burst;
                end
                send(random_cmd());
            end
        end

        settle(40);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
